// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the grid reachability RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid reachability check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid reachability check failed");

`endif

// ----- hdl/mgr_pkg.sv -----
// Shared types and constants of the monotone grid reachability block.
// No dependencies; mgr_in_if, the top level and mgr_cell import this package.
package mgr_pkg;

    // Width of the coordinate fields and of the count registers
    localparam int FIELD_W   = 7;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

    // Count register reset value
    localparam logic [FIELD_W-1:0] COUNT_RESET = 7'd64;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_WRITE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } mgr_state_t;

    // Control part of a row token moving down the cell chain
    typedef struct packed {
        logic valid;   // token carries a row
        logic first;   // start row of the query
        logic last;    // goal row of the query
        logic reach;   // reach bit of the left neighbor for this row
        logic ans;     // answer picked up at the goal column
    } mgr_tok_t;

endpackage

// ----- hdl/mgr_in_if.sv -----
// Command channel: grid cell writes and reachability queries.
// Depends on mgr_pkg for the field width.
interface mgr_in_if
    import mgr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               command;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] goal_row;
    logic [FIELD_W-1:0] goal_column;
    logic               blocked;

    modport source (
        output valid, command, row, column, goal_row, goal_column, blocked,
        input  ready
    );

    modport sink (
        input  valid, command, row, column, goal_row, goal_column, blocked,
        output ready
    );
endinterface

// ----- hdl/mgr_out_if.sv -----
// Result channel: one reachability answer per query.
// Standalone; no package needed.
interface mgr_out_if;
    logic valid;
    logic ready;
    logic reachable;

    modport source (
        output valid, reachable,
        input  ready
    );

    modport sink (
        input  valid, reachable,
        output ready
    );
endinterface

// ----- hdl/monotone_grid_reachability.sv -----
// Top level of the monotone grid reachability block: configuration, control,
// grid RAM and the column cell chain. Uses mgr_pkg, mgr_in_if, mgr_out_if,
// mgr_ram, mgr_cell and assert_macros.svh.
//
//  channel | role   | handshake            | payload
//  --------+--------+----------------------+------------------------------------------
//  cmd     | sink   | valid/ready          | command, row, column, goal_row,
//          |        |                      | goal_column, blocked
//  rsp     | source | valid/ready          | reachable
//  cfg     | sink   | cfg_write, no ready  | cfg_index, cfg_data
//
// A cell write reads the row word, then writes it back in ST_WR_WRITE; an out of
// range write is dropped in ST_IDLE. A trivial query goes through ST_FINISH to the
// result register. A swept query reads one grid row word per cycle, from row to
// goal_row, and each row then walks the chain of MAX_COLUMNS cells.
// Reset clears the row valid flops at once, so the grid reads as free with no
// clearing pass. One item is in work at a time; a waiting result holds in rsp.
`include "assert_macros.svh"

module monotone_grid_reachability
    import mgr_pkg::*;
#(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mgr_in_if.sink               cmd,
    mgr_out_if.source            rsp,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int COL_AW = $clog2(MAX_COLUMNS);
    localparam int LIM_W  = $clog2(((MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS) + 1);
    localparam int CMP_W  = (LIM_W > FIELD_W) ? LIM_W : FIELD_W;
    localparam logic [CMP_W-1:0] MAX_R = CMP_W'(MAX_ROWS);
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_COLUMNS);
    localparam logic [CMP_W-1:0] ONE   = CMP_W'(1);

    // Configuration registers
    logic [FIELD_W-1:0] row_count_reg;
    logic [FIELD_W-1:0] column_count_reg;

    // Controller registers
    mgr_state_t        state_reg, state_next;
    logic [ROW_AW-1:0] cur_row_reg, cur_row_next;
    logic [ROW_AW-1:0] end_row_reg, end_row_next;
    logic [COL_AW-1:0] start_col_reg, start_col_next;
    logic [COL_AW-1:0] goal_col_reg, goal_col_next;
    logic [ROW_AW-1:0] wr_row_reg, wr_row_next;
    logic [COL_AW-1:0] wr_col_reg, wr_col_next;
    logic              wr_blk_reg, wr_blk_next;
    logic              ans_reg, ans_next;
    mgr_tok_t          feed_tok_reg;
    mgr_tok_t          issue_tok;
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic              rd_row_valid_reg;
    logic              out_valid_reg;
    logic              reachable_reg;
    logic              out_load;

    // RAM signals
    logic                   ram_we;
    logic [ROW_AW-1:0]      ram_raddr;
    logic [MAX_COLUMNS-1:0] ram_rdata;
    logic [MAX_COLUMNS-1:0] ram_wdata;
    logic [MAX_COLUMNS-1:0] row_word;

    // Query decode
    logic [CMP_W-1:0] sr_x, sc_x, gr_x, gc_x, nr, nc, rc_x, cc_x;
    logic             q_same, q_in_range, q_ordered, q_sweep, q_one_row, wr_ok;

    // Chain wiring
    mgr_tok_t               tok_chain  [MAX_COLUMNS+1];
    logic [MAX_COLUMNS-1:0] word_chain [MAX_COLUMNS+1];
    mgr_tok_t               end_tok;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= COUNT_RESET;
            column_count_reg <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp counts and classify the incoming item
    always_comb
    begin
        sr_x = CMP_W'(cmd.row);
        sc_x = CMP_W'(cmd.column);
        gr_x = CMP_W'(cmd.goal_row);
        gc_x = CMP_W'(cmd.goal_column);
        rc_x = CMP_W'(row_count_reg);
        cc_x = CMP_W'(column_count_reg);
        nr   = (rc_x > MAX_R) ? MAX_R : rc_x;
        nc   = (cc_x > MAX_C) ? MAX_C : cc_x;
        q_same     = (sr_x == gr_x) && (sc_x == gc_x);
        q_in_range = (sr_x >= ONE) && (sr_x <= nr) && (gr_x >= ONE) && (gr_x <= nr) &&
                     (sc_x >= ONE) && (sc_x <= nc) && (gc_x >= ONE) && (gc_x <= nc);
        q_ordered  = (gr_x >= sr_x) && (gc_x >= sc_x);
        q_sweep    = !q_same && q_in_range && q_ordered;
        q_one_row  = (sr_x == gr_x);
        wr_ok      = (sr_x >= ONE) && (sr_x <= MAX_R) && (sc_x >= ONE) && (sc_x <= MAX_C);
    end

    assign row_word = rd_row_valid_reg ? ram_rdata : '0;

    // Next state, RAM access and row issue
    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        end_row_next   = end_row_reg;
        start_col_next = start_col_reg;
        goal_col_next  = goal_col_reg;
        wr_row_next    = wr_row_reg;
        wr_col_next    = wr_col_reg;
        wr_blk_next    = wr_blk_reg;
        ans_next       = ans_reg;
        issue_tok      = '0;
        ram_raddr      = ROW_AW'(sr_x - ONE);
        ram_we         = 1'b0;
        out_load       = 1'b0;
        ram_wdata      = row_word;
        ram_wdata[wr_col_reg] = wr_blk_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.command == CMD_WRITE)
                    begin
                        wr_row_next = ROW_AW'(sr_x - ONE);
                        wr_col_next = COL_AW'(sc_x - ONE);
                        wr_blk_next = cmd.blocked;
                        if (wr_ok)
                        begin
                            state_next = ST_WR_WRITE;
                        end
                    end
                    else
                    begin
                        start_col_next = COL_AW'(sc_x - ONE);
                        goal_col_next  = COL_AW'(gc_x - ONE);
                        end_row_next   = ROW_AW'(gr_x - ONE);
                        cur_row_next   = ROW_AW'(sr_x);
                        if (q_sweep)
                        begin
                            issue_tok.valid = 1'b1;
                            issue_tok.first = 1'b1;
                            issue_tok.last  = q_one_row;
                            state_next      = q_one_row ? ST_DRAIN : ST_SWEEP;
                        end
                        else
                        begin
                            ans_next   = q_same;
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_WR_WRITE:
            begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                ram_raddr       = cur_row_reg;
                issue_tok.valid = 1'b1;
                issue_tok.last  = (cur_row_reg == end_row_reg);
                if (cur_row_reg == end_row_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cur_row_next = cur_row_reg + ROW_AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (end_tok.valid && end_tok.last)
                begin
                    ans_next   = end_tok.ans;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cmd.ready = (state_reg == ST_IDLE);

    // Hold controller state and row valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            feed_tok_reg  <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            feed_tok_reg <= issue_tok;
            if (ram_we)
            begin
                row_valid_reg[wr_row_reg] <= 1'b1;
            end
        end
    end

    // Hold query and write operands
    always_ff @(posedge clk)
    begin
        cur_row_reg      <= cur_row_next;
        end_row_reg      <= end_row_next;
        start_col_reg    <= start_col_next;
        goal_col_reg     <= goal_col_next;
        wr_row_reg       <= wr_row_next;
        wr_col_reg       <= wr_col_next;
        wr_blk_reg       <= wr_blk_next;
        ans_reg          <= ans_next;
        rd_row_valid_reg <= row_valid_reg[ram_raddr];
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            reachable_reg <= ans_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.reachable = reachable_reg;

    // Grid store, one row word per entry
    mgr_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_row_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Column cell chain
    assign tok_chain[0]  = feed_tok_reg;
    assign word_chain[0] = row_word;

    for (genvar c = 0; c < MAX_COLUMNS; c++)
    begin : g_cell
        mgr_cell #(
            .IDX  (c),
            .COLS (MAX_COLUMNS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .start_col (start_col_reg),
            .goal_col  (goal_col_reg),
            .tok_in    (tok_chain[c]),
            .word_in   (word_chain[c]),
            .tok_out   (tok_chain[c+1]),
            .word_out  (word_chain[c+1])
        );
    end

    assign end_tok = tok_chain[MAX_COLUMNS];

    // Assertions
    `ASSERT_SAME(a_end_tok_in_drain, end_tok.valid && end_tok.last, state_reg == ST_DRAIN)
    `ASSERT_SAME(a_feed_in_query, feed_tok_reg.valid,
                 state_reg == ST_SWEEP || state_reg == ST_DRAIN)
    `ASSERT_SAME(a_write_after_read, state_reg == ST_WR_WRITE, $past(state_reg) == ST_IDLE)
    `ASSERT_NEXT(a_result_loaded, out_load, out_valid_reg && reachable_reg == $past(ans_reg))

endmodule

// ----- hdl/mgr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mgr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- hdl/mgr_cell.sv -----
// One column cell of the reachability chain: holds the column's reach bit
// and passes each row token to the next column through its token register. Uses mgr_pkg.
module mgr_cell
    import mgr_pkg::*;
#(
    parameter int IDX  = 0,
    parameter int COLS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [$clog2(COLS)-1:0]  start_col,
    input  logic [$clog2(COLS)-1:0]  goal_col,
    input  mgr_tok_t                 tok_in,
    input  logic [COLS-1:0]          word_in,
    output mgr_tok_t                 tok_out,
    output logic [COLS-1:0]          word_out
);

    localparam int COL_AW = $clog2(COLS);
    localparam logic [COL_AW-1:0] MY_COL = COL_AW'(IDX);

    logic     reach_reg;
    mgr_tok_t tok_reg;
    logic [COLS-1:0] word_reg;
    logic     is_start;
    logic     here;
    mgr_tok_t tok_next;

    // Reach of this cell for the incoming row
    always_comb
    begin
        is_start = tok_in.first && (start_col == MY_COL);
        here     = is_start ||
                   (!word_in[IDX] && ((!tok_in.first && reach_reg) || tok_in.reach));
        tok_next       = tok_in;
        tok_next.reach = here;
        if (tok_in.last && (goal_col == MY_COL))
        begin
            tok_next.ans = here;
        end
    end

    // Hold the reach bit of the most recent row
    always_ff @(posedge clk)
    begin
        if (tok_in.valid)
        begin
            reach_reg <= here;
        end
        word_reg <= word_in;
    end

    // Advance the token to the next column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out  = tok_reg;
    assign word_out = word_reg;

endmodule
